// ===== hdl/slirm_pkg.sv =====
package slirm_pkg;

  // Field widths of the transfer payloads
  localparam int unsigned OP_W     = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ENTRY_W  = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [ENTRY_W-1:0]        entry_count;
    logic                      is_empty;
    logic                      is_full;
  } rsp_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_FETCH,
    S_FINISH
  } seq_state_t;

endpackage

// ===== hdl/slirm_mem.sv =====
module slirm_mem import slirm_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [VALUE_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/slirm_seq.sv =====
module slirm_seq import slirm_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_item_t          req,
  input  logic               res_free,
  output logic               res_load,
  output rsp_item_t          res,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [VALUE_W-1:0] mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  logic [VALUE_W-1:0] mem_rdata
);

  seq_state_t                state, state_next;
  logic [CW-1:0]             count, count_next;
  logic [AW-1:0]             idx, idx_next;
  logic signed [VALUE_W-1:0] val, val_next;
  logic [STATUS_W-1:0]       status, status_next;
  logic [VALUE_W-1:0]        removed, removed_next;

  logic [CW-1:0]             count_m1;
  logic [AW-1:0]             last_idx;
  logic [AW-1:0]             idx_up;
  logic [AW-1:0]             idx_dn;
  logic                      full;
  logic [CW+ENTRY_W-1:0]     count_ext;

  assign count_m1  = count - CW'(1);
  assign last_idx  = count_m1[AW-1:0];
  assign idx_up    = idx + AW'(1);
  assign idx_dn    = idx - AW'(1);
  assign full      = (count == CW'(DEPTH));
  assign count_ext = {{ENTRY_W{1'b0}}, count};

  // Result fields come from the registered item state
  always_comb begin
    res.status        = status;
    res.removed_value = removed;
    res.entry_count   = count_ext[ENTRY_W-1:0];
    res.is_empty      = (count == '0);
    res.is_full       = full;
  end

  // Next state, memory requests and item registers
  always_comb begin
    state_next   = state;
    count_next   = count;
    idx_next     = idx;
    val_next     = val;
    status_next  = status;
    removed_next = removed;
    req_stall    = (state != S_IDLE);
    res_load     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = idx_up;
    mem_wdata    = mem_rdata;
    mem_raddr    = idx_dn;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          val_next     = req.value;
          status_next  = ST_OK;
          removed_next = '0;
          state_next   = S_FINISH;
          case (req.operation)
            OP_INSERT: begin
              if (full) begin
                status_next = ST_FULL;
              end else if (count == '0) begin
                // empty store: the value lands in slot zero at once
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = req.value;
                count_next = count + CW'(1);
              end else begin
                // walk down from the last slot, shifting entries >= the value up
                mem_raddr  = last_idx;
                idx_next   = last_idx;
                count_next = count + CW'(1);
                state_next = S_SHIFT;
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                mem_raddr  = last_idx;
                count_next = count_m1;
                state_next = S_FETCH;
              end
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end

      S_SHIFT: begin
        mem_we = 1'b1;
        if ($signed(mem_rdata) >= val) begin
          // move this entry up one slot and look at the next lower one
          mem_wdata = mem_rdata;
          if (idx == '0) begin
            state_next = S_PLACE;
          end else begin
            idx_next = idx_dn;
          end
        end else begin
          mem_wdata  = val;
          state_next = S_FINISH;
        end
      end

      S_PLACE: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = val;
        state_next = S_FINISH;
      end

      S_FETCH: begin
        removed_next = mem_rdata;
        state_next   = S_FINISH;
      end

      S_FINISH: begin
        // hold until the result register is free
        if (res_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    val     <= val_next;
    status  <= status_next;
    removed <= removed_next;
  end

endmodule

// ===== hdl/sorted_list_insert_remove_max.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_item_t (operation, value)
// rsp       out        rsp_valid / rsp_stall  rsp_item_t (status, removed_value,
//                                             entry_count, is_empty, is_full)
//
// One item at a time. Query, refused insert, empty remove and insert into an
// empty store go straight to the finish state. Remove adds one memory read.
// Other inserts walk down over the stored values >= the new value; one entry is
// shifted per cycle through the single read and write ports of the value memory.
// Synchronous reset empties the store; memory contents are left as they are.
// A stalled result waits in the output register; the next item is accepted
// while it waits and finishes once the register frees up.
module sorted_list_insert_remove_max import slirm_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic               res_free;
  logic               res_load;
  rsp_item_t          res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  slirm_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  slirm_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register is free when empty or when its result transfers now
  assign res_free = !rsp_valid || !rsp_stall;

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp <= res;
    end
  end

endmodule
